// File: sv/gps_pkg.sv
// Shared types and constants for the grid path search block.
// No dependencies; used by gps_engine and grid_path_search_backtrace.
package gps_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOPATH = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // move directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_START_COL   = 3'd2;
  localparam logic [2:0] REG_START_ROW   = 3'd3;
  localparam logic [2:0] REG_GOAL_COL    = 3'd4;
  localparam logic [2:0] REG_GOAL_ROW    = 3'd5;

  // cell memory word: wall, explored, came-from direction
  localparam int CM_W    = 4;
  localparam int CM_WALL = 0;
  localparam int CM_EXPL = 1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  cell_col;
    logic [4:0]  cell_row;
    logic        wall_bit;
    logic [11:0] step_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  path_col;
    logic [4:0]  path_row;
    logic [11:0] path_length;
    logic        path_found;
  } out_item_t;

  typedef struct packed {
    logic [7:0] grid_width;
    logic [5:0] grid_height;
    logic [6:0] start_col;
    logic [4:0] start_row;
    logic [6:0] goal_col;
    logic [4:0] goal_row;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_stat_t;

endpackage

// File: sv/grid_path_search_backtrace.sv
// Top level of the grid path search block: config registers, request
// handshake and output register. Depends on gps_pkg and gps_engine.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_stall_o, in_item_i         | request in
//  out      | out_valid_o, out_stall_i, out_item_o      | result out
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i/data| write in
//
// A write or read request needs at most one RAM access state before its result; a
// search runs the explored-map clearing sweep, then for each cell popped a pop
// and a wait state, a check of each direction and a RAM read per neighbor in
// range, and finally a RAM read and a step for each cell on the path back.
// Reset leaves the wall map undefined; no path is stored after reset.
// A new request is taken once the previous result sits in the output register.
module grid_path_search_backtrace #(
  parameter int MaxCols = 128,
  parameter int MaxRows = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gps_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gps_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import gps_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  out_item_t res;
  eng_stat_t stat;
  logic      res_take, start;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !stat.idle;
  assign start       = in_valid_i && stat.idle;
  assign res_take    = !out_valid_q || !out_stall_i;

  gps_engine #(.MaxCols(MaxCols), .MaxRows(MaxRows)) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_item_i),
    .cfg_i      (cfg_q),
    .res_take_i (res_take),
    .res_o      (res),
    .stat_o     (stat)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:  cfg_d.grid_width  = cfg_data_i;
        REG_GRID_HEIGHT: cfg_d.grid_height = cfg_data_i[5:0];
        REG_START_COL:   cfg_d.start_col   = cfg_data_i[6:0];
        REG_START_ROW:   cfg_d.start_row   = cfg_data_i[4:0];
        REG_GOAL_COL:    cfg_d.goal_col    = cfg_data_i[6:0];
        REG_GOAL_ROW:    cfg_d.goal_row    = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (stat.res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= 8'd65;
      cfg_q.grid_height <= 6'd23;
      cfg_q.start_col   <= 7'd1;
      cfg_q.start_row   <= 5'd1;
      cfg_q.goal_col    <= 7'd63;
      cfg_q.goal_row    <= 5'd21;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: sv/gps_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module gps_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/gps_engine.sv
// Search sequencer: cell map RAM (wall/explored/direction) and stack RAM,
// which holds the path after a backtrace. Depends on gps_pkg and gps_ram.
module gps_engine #(
  parameter int MaxCols = 128,
  parameter int MaxRows = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gps_pkg::in_item_t  item_i,
  input  gps_pkg::cfg_t      cfg_i,
  input  logic               res_take_i,
  output gps_pkg::out_item_t res_o,
  output gps_pkg::eng_stat_t stat_o
);
  import gps_pkg::*;

  localparam int CW     = $clog2(MaxCols);
  localparam int RW     = $clog2(MaxRows);
  localparam int AW     = CW + RW;
  localparam int Depth  = 2 ** AW;
  localparam int NCells = MaxCols * MaxRows;
  localparam int XW     = ((CW > 7) ? CW : 7) + 2;
  localparam int YW     = ((RW > 5) ? RW : 5) + 2;
  localparam int LW     = ((AW + 1) > 12) ? (AW + 1) : 12;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_WMOD  = 13'b0000000000010,
    S_RDW   = 13'b0000000000100,
    S_CLR   = 13'b0000000001000,
    S_SCHK  = 13'b0000000010000,
    S_SMARK = 13'b0000000100000,
    S_POP   = 13'b0000001000000,
    S_POPW  = 13'b0000010000000,
    S_NB    = 13'b0000100000000,
    S_NBW   = 13'b0001000000000,
    S_BT    = 13'b0010000000000,
    S_BTW   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e         state_q, state_d;
  in_item_t       item_q, item_d;
  logic [AW:0]    cnt_q, cnt_d;      // clear sweep / backtrace step count
  logic [AW:0]    sp_q, sp_d;
  logic [AW:0]    len_q, len_d;
  logic           found_q, found_d;
  logic [1:0]     status_q, status_d;
  logic [6:0]     pcol_q, pcol_d;
  logic [4:0]     prow_q, prow_d;
  logic [CW-1:0]  ccol_q, ccol_d;
  logic [RW-1:0]  crow_q, crow_d;
  logic [1:0]     dir_q, dir_d;

  logic            cm_we, sm_we;
  logic [AW-1:0]   cm_waddr, cm_raddr, sm_waddr, sm_raddr;
  logic [CM_W-1:0] cm_wdata, cm_rdata;
  logic [AW-1:0]   sm_wdata, sm_rdata;

  gps_ram #(.Width(CM_W), .Depth(Depth)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_waddr),
    .wdata_i (cm_wdata),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  gps_ram #(.Width(AW), .Depth(Depth)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (sm_raddr),
    .rdata_o (sm_rdata)
  );

  // grid in use, saturated at storage size
  logic [XW-1:0] grid_w;
  logic [YW-1:0] grid_h;
  assign grid_w = (XW'(cfg_i.grid_width) < XW'(MaxCols)) ? XW'(cfg_i.grid_width)
                                                        : XW'(MaxCols);
  assign grid_h = (YW'(cfg_i.grid_height) < YW'(MaxRows)) ? YW'(cfg_i.grid_height)
                                                         : YW'(MaxRows);

  logic [AW-1:0] start_addr, cur_addr, pop_addr;
  logic          start_in, start_is_goal, pop_is_goal, cur_is_start;
  assign start_addr = {RW'(cfg_i.start_row), CW'(cfg_i.start_col)};
  assign cur_addr   = {crow_q, ccol_q};
  assign start_in   = (XW'(cfg_i.start_col) < grid_w) && (YW'(cfg_i.start_row) < grid_h);
  assign start_is_goal = (cfg_i.start_col == cfg_i.goal_col) &&
                         (cfg_i.start_row == cfg_i.goal_row);
  assign pop_addr    = sm_rdata;
  assign pop_is_goal = (XW'(pop_addr[CW-1:0]) == XW'(cfg_i.goal_col)) &&
                       (YW'(pop_addr[AW-1:CW]) == YW'(cfg_i.goal_row));
  assign cur_is_start = (XW'(ccol_q) == XW'(cfg_i.start_col)) &&
                        (YW'(crow_q) == YW'(cfg_i.start_row));

  // neighbor of the current cell; a left/up step from zero wraps to all ones
  logic [XW-1:0] ncol;
  logic [YW-1:0] nrow;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  always_comb begin
    ncol = XW'(ccol_q);
    nrow = YW'(crow_q);
    case (dir_q)
      DIR_UP:    nrow = nrow - YW'(1);
      DIR_RIGHT: ncol = ncol + XW'(1);
      DIR_DOWN:  nrow = nrow + YW'(1);
      default:   ncol = ncol - XW'(1);
    endcase
  end
  assign nb_ok = (ncol != '0) && ((XW+1)'(ncol) + (XW+1)'(1) < (XW+1)'(grid_w)) &&
                 (nrow != '0) && ((YW+1)'(nrow) + (YW+1)'(1) < (YW+1)'(grid_h));
  assign nb_addr = {nrow[RW-1:0], ncol[CW-1:0]};

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    cnt_d    = cnt_q;
    sp_d     = sp_q;
    len_d    = len_q;
    found_d  = found_q;
    status_d = status_q;
    pcol_d   = pcol_q;
    prow_d   = prow_q;
    ccol_d   = ccol_q;
    crow_d   = crow_q;
    dir_d    = dir_q;
    cm_we    = 1'b0;
    cm_waddr = cur_addr;
    cm_wdata = cm_rdata;
    cm_raddr = cur_addr;
    sm_we    = 1'b0;
    sm_waddr = AW'(sp_q);
    sm_wdata = cur_addr;
    sm_raddr = AW'(sp_q - (AW+1)'(1));

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d   = item_i;
          status_d = ST_OK;
          pcol_d   = '0;
          prow_d   = '0;
          state_d  = S_DONE;
          case (item_i.cmd)
            CMD_WRITE: begin
              if ((XW'(item_i.cell_col) < XW'(MaxCols)) &&
                  (YW'(item_i.cell_row) < YW'(MaxRows))) begin
                cm_raddr = {RW'(item_i.cell_row), CW'(item_i.cell_col)};
                state_d  = S_WMOD;
              end
            end
            CMD_SEARCH: begin
              cnt_d   = '0;
              len_d   = '0;
              found_d = 1'b0;
              state_d = S_CLR;
            end
            CMD_READ: begin
              if (!found_q) begin
                status_d = ST_NOPATH;
              end else if (LW'(item_i.step_index) >= LW'(len_q)) begin
                status_d = ST_RANGE;
              end else begin
                sm_raddr = AW'(item_i.step_index);
                state_d  = S_RDW;
              end
            end
            default: ;
          endcase
        end
      end
      S_WMOD: begin
        cm_we    = 1'b1;
        cm_waddr = {RW'(item_q.cell_row), CW'(item_q.cell_col)};
        cm_wdata = cm_rdata;
        cm_wdata[CM_WALL] = item_q.wall_bit;
        state_d  = S_DONE;
      end
      S_RDW: begin
        pcol_d  = 7'(sm_rdata[CW-1:0]);
        prow_d  = 5'(sm_rdata[AW-1:CW]);
        state_d = S_DONE;
      end
      S_CLR: begin
        // read entry cnt, write back entry cnt-1 with explored cleared
        cm_raddr = AW'(cnt_q);
        cm_waddr = AW'(cnt_q - (AW+1)'(1));
        cm_wdata = cm_rdata;
        cm_wdata[CM_EXPL] = 1'b0;
        cm_we    = (cnt_q != '0);
        cnt_d    = cnt_q + (AW+1)'(1);
        if (cnt_q == (AW+1)'(Depth)) begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (!start_in) begin
          status_d = ST_NOPATH;
          state_d  = S_DONE;
        end else if (start_is_goal) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cm_raddr = start_addr;
          state_d  = S_SMARK;
        end
      end
      S_SMARK: begin
        cm_we    = 1'b1;
        cm_waddr = start_addr;
        cm_wdata = cm_rdata;
        cm_wdata[CM_EXPL] = 1'b1;
        sm_we    = 1'b1;
        sm_waddr = '0;
        sm_wdata = start_addr;
        sp_d     = (AW+1)'(1);
        state_d  = S_POP;
      end
      S_POP: begin
        if (sp_q == '0) begin
          status_d = ST_NOPATH;
          state_d  = S_DONE;
        end else begin
          sp_d    = sp_q - (AW+1)'(1);
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        ccol_d = pop_addr[CW-1:0];
        crow_d = pop_addr[AW-1:CW];
        dir_d  = DIR_UP;
        cnt_d  = '0;
        state_d = pop_is_goal ? S_BT : S_NB;
      end
      S_NB: begin
        cm_raddr = nb_addr;
        if (nb_ok) begin
          state_d = S_NBW;
        end else if (dir_q == DIR_LEFT) begin
          state_d = S_POP;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      S_NBW: begin
        if (!cm_rdata[CM_WALL] && !cm_rdata[CM_EXPL]) begin
          cm_we    = 1'b1;
          cm_waddr = nb_addr;
          cm_wdata = {dir_q, 1'b1, cm_rdata[CM_WALL]};
          if (sp_q < (AW+1)'(NCells)) begin
            sm_we    = 1'b1;
            sm_waddr = AW'(sp_q);
            sm_wdata = nb_addr;
            sp_d     = sp_q + (AW+1)'(1);
          end
        end
        if (dir_q == DIR_LEFT) begin
          state_d = S_POP;
        end else begin
          dir_d   = dir_q + 2'd1;
          state_d = S_NB;
        end
      end
      S_BT: begin
        if (cur_is_start || (cnt_q == (AW+1)'(NCells))) begin
          found_d = 1'b1;
          len_d   = cnt_q;
          state_d = S_DONE;
        end else begin
          cm_raddr = cur_addr;
          sm_we    = 1'b1;
          sm_waddr = AW'(cnt_q);
          sm_wdata = cur_addr;
          cnt_d    = cnt_q + (AW+1)'(1);
          state_d  = S_BTW;
        end
      end
      S_BTW: begin
        // step back against the direction the cell was entered by
        case (cm_rdata[CM_W-1:2])
          DIR_UP:    crow_d = crow_q + RW'(1);
          DIR_RIGHT: ccol_d = ccol_q - CW'(1);
          DIR_DOWN:  crow_d = crow_q - RW'(1);
          default:   ccol_d = ccol_q + CW'(1);
        endcase
        state_d = S_BT;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      len_q   <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      len_q   <= len_d;
      found_q <= found_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    pcol_q   <= pcol_d;
    prow_q   <= prow_d;
    ccol_q   <= ccol_d;
    crow_q   <= crow_d;
    dir_q    <= dir_d;
  end

  assign res_o.status      = status_q;
  assign res_o.path_col    = pcol_q;
  assign res_o.path_row    = prow_q;
  assign res_o.path_length = (LW'(len_q) > LW'(12'hFFF)) ? 12'hFFF : 12'(len_q);
  assign res_o.path_found  = found_q;
  assign stat_o.idle       = (state_q == S_IDLE);
  assign stat_o.res_valid  = (state_q == S_DONE);

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= (AW+1)'(NCells))
    else $error("stack pointer beyond cell count");
  a_popw_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POPW) |-> ($past(state_q) == S_POP))
    else $error("stack read data used without a pop");
  a_len_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!found_q) |-> (len_q == '0))
    else $error("path length set without a found path");
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && item_q.cmd == CMD_SEARCH) |->
      (found_q == (status_q == ST_OK)))
    else $error("search status disagrees with found flag");
`endif

endmodule

// File: test/grid_path_search_backtrace_test.sv
// Testbench for grid_path_search_backtrace: a directed table, then random
// wall/search/read sequences checked against an in-bench path predictor.
// Depends on gps_pkg and the grid_path_search_backtrace RTL.
`timescale 1ns / 100ps

module grid_path_search_backtrace_test;
  import gps_pkg::*;

  localparam int NCOLS  = 128;
  localparam int NROWS  = 32;
  localparam int NCELLS = NCOLS * NROWS;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [2:0] reg_idx;
    logic [7:0] reg_val;
    in_item_t   req;
    bit         typed;
    out_item_t  res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  grid_path_search_backtrace dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // predictor state
  cfg_t       grid_cfg;
  bit         wall_mem [NCELLS];
  bit         seen_mem [NCELLS];
  logic [1:0] from_dir [NCELLS];
  int         dfs_stack [NCELLS];
  int         trace_col [NCELLS];
  int         trace_row [NCELLS];
  int         trace_len;
  bit         path_ok;

  out_item_t  pending_res[$];
  stim_row_t  stim_table[$];
  int         mismatches;
  bit         hold_req;

  function automatic int step_dc(logic [1:0] d);
    case (d)
      DIR_RIGHT: return 1;
      DIR_LEFT:  return -1;
      default:   return 0;
    endcase
  endfunction

  function automatic int step_dr(logic [1:0] d);
    case (d)
      DIR_UP:   return -1;
      DIR_DOWN: return 1;
      default:  return 0;
    endcase
  endfunction

  function automatic void search_path();
    int w, h, sc, sr, gc, gr, sp, a, c, r, nc, nr, na, n;
    logic [1:0] d;
    w  = (grid_cfg.grid_width < NCOLS) ? int'(grid_cfg.grid_width) : NCOLS;
    h  = (grid_cfg.grid_height < NROWS) ? int'(grid_cfg.grid_height) : NROWS;
    sc = grid_cfg.start_col;
    sr = grid_cfg.start_row;
    gc = grid_cfg.goal_col;
    gr = grid_cfg.goal_row;
    sp = 0;
    foreach (seen_mem[i]) seen_mem[i] = 0;
    trace_len = 0;
    path_ok   = 0;
    if (sc >= w || sr >= h) return;
    if (sc == gc && sr == gr) begin
      path_ok = 1;
      return;
    end
    seen_mem[sr * NCOLS + sc] = 1;
    dfs_stack[sp] = sr * NCOLS + sc;
    sp = sp + 1;
    while (sp > 0) begin
      sp = sp - 1;
      a = dfs_stack[sp];
      c = a % NCOLS;
      r = a / NCOLS;
      if (c == gc && r == gr) begin
        n = 0;
        while (!(c == sc && r == sr) && n < NCELLS) begin
          d = from_dir[r * NCOLS + c];
          trace_col[n] = c;
          trace_row[n] = r;
          n++;
          c -= step_dc(d);
          r -= step_dr(d);
        end
        trace_len = n;
        path_ok   = 1;
        return;
      end
      for (int k = 0; k < 4; k++) begin
        d  = k[1:0];
        nc = c + step_dc(d);
        nr = r + step_dr(d);
        if (nc <= 0 || nc >= w - 1 || nr <= 0 || nr >= h - 1) continue;
        na = nr * NCOLS + nc;
        if (wall_mem[na] || seen_mem[na]) continue;
        seen_mem[na] = 1;
        from_dir[na] = d;
        if (sp < NCELLS) begin
          dfs_stack[sp] = na;
          sp = sp + 1;
        end
      end
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    res = '0;
    case (req.cmd)
      CMD_WRITE: wall_mem[req.cell_row * NCOLS + req.cell_col] = req.wall_bit;
      CMD_SEARCH: begin
        search_path();
        res.status = path_ok ? ST_OK : ST_NOPATH;
      end
      CMD_READ: begin
        if (!path_ok) res.status = ST_NOPATH;
        else if (req.step_index >= trace_len) res.status = ST_RANGE;
        else begin
          res.path_col = 7'(trace_col[req.step_index]);
          res.path_row = 5'(trace_row[req.step_index]);
        end
      end
      default: ;
    endcase
    res.path_length = (trace_len > 4095) ? 12'd4095 : trace_len[11:0];
    res.path_found  = path_ok;
    return res;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      REG_GRID_WIDTH:  grid_cfg.grid_width  = val;
      REG_GRID_HEIGHT: grid_cfg.grid_height = val[5:0];
      REG_START_COL:   grid_cfg.start_col   = val[6:0];
      REG_START_ROW:   grid_cfg.start_row   = val[4:0];
      REG_GOAL_COL:    grid_cfg.goal_col    = val[6:0];
      REG_GOAL_ROW:    grid_cfg.goal_row    = val[4:0];
      default: ;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // request sender; typed rows queue their own expectation
  task automatic send_req(in_item_t req, int gap, bit typed, out_item_t res);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    in_item  = req;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      void'(predict_result(req));
      pending_res = {pending_res, res};
    end else begin
      pending_res = {pending_res, predict_result(req)};
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    in_valid = 0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic in_item_t make_req(logic [1:0] cmd, int col, int row, bit wall, int step);
    in_item_t req;
    req.cmd        = cmd;
    req.cell_col   = col[6:0];
    req.cell_row   = row[4:0];
    req.wall_bit   = wall;
    req.step_index = step[11:0];
    return req;
  endfunction

  task automatic add_item(in_item_t req);
    stim_row_t row;
    row = '{ROW_ITEM, '0, '0, req, 0, '0};
    stim_table = {stim_table, row};
  endtask

  task automatic add_typed(in_item_t req, logic [1:0] st, bit found);
    stim_row_t row;
    out_item_t res;
    res = '0;
    res.status = st;
    res.path_found = found;
    row = '{ROW_ITEM, '0, '0, req, 1, res};
    stim_table = {stim_table, row};
  endtask

  task automatic add_cfg(logic [2:0] idx, logic [7:0] val);
    stim_row_t row;
    row = '{ROW_CFG, idx, val, '0, 0, '0};
    stim_table = {stim_table, row};
  endtask

  task automatic run_table();
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG)
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
      else
        send_req(stim_table[i].req, $urandom_range(0, 7), stim_table[i].typed,
                 stim_table[i].res);
    end
    stim_table.delete();
  endtask

  // result side: random stall per result, plus one long hold-off on request
  initial begin
    int stall_cnt;
    int hold_cnt;
    out_item_t exp_res;
    stall_cnt = 0;
    hold_cnt  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt == 0) hold_cnt = 300;
      if (hold_cnt > 0) begin
        out_stall = 1;
        hold_cnt--;
        if (hold_cnt == 0) hold_req = 0;
      end else if (stall_cnt > 0) begin
        out_stall = 1;
        stall_cnt--;
      end else begin
        out_stall = 0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        stall_cnt = $urandom_range(0, 7);
        if (pending_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          exp_res = pending_res.pop_front();
          if (out_item.status !== exp_res.status ||
              out_item.path_col !== exp_res.path_col ||
              out_item.path_row !== exp_res.path_row ||
              out_item.path_length !== exp_res.path_length ||
              out_item.path_found !== exp_res.path_found) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", exp_res, out_item);
          end
        end
      end
    end
  end

  initial begin
    int w, h, n_rand, phase, wait_cyc, col, row;
    in_valid   = 0;
    in_item    = '0;
    out_stall  = 0;
    cfg_valid  = 0;
    cfg_index  = '0;
    cfg_data   = '0;
    hold_req   = 0;
    mismatches = 0;
    rst_n      = 0;
    grid_cfg   = '{8'd65, 6'd23, 7'd1, 5'd1, 7'd63, 5'd21};
    trace_len  = 0;
    path_ok    = 0;
    foreach (wall_mem[i]) wall_mem[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // nothing stored after reset
    add_typed(make_req(CMD_READ, 0, 0, 0, 0), ST_NOPATH, 0);
    add_typed(make_req(CMD_READ, 127, 31, 1, 4095), ST_NOPATH, 0);
    add_typed(make_req(2'd3, 127, 31, 1, 4095), ST_OK, 0);
    run_table();

    // define the corner region every search stays in; column 9 and row 7
    // are walls that fence in searches on larger grids
    for (int r = 1; r <= 7; r++)
      for (int c = 1; c <= 9; c++)
        send_req(make_req(CMD_WRITE, c, r, (c == 9 || r == 7 || $urandom_range(0, 9) == 0),
                          0), $urandom_range(0, 7), 0, '0);

    add_item(make_req(CMD_SEARCH, 0, 0, 0, 0));
    add_item(make_req(CMD_READ, 0, 0, 0, 0));
    add_item(make_req(CMD_READ, 0, 0, 0, 4095));
    // start equals goal: found with an empty path
    add_cfg(REG_GOAL_COL, 8'd1);
    add_cfg(REG_GOAL_ROW, 8'd1);
    add_typed(make_req(CMD_SEARCH, 0, 0, 0, 0), ST_OK, 1);
    add_typed(make_req(CMD_READ, 0, 0, 0, 0), ST_RANGE, 1);
    // start outside the grid
    add_cfg(REG_START_COL, 8'd127);
    add_cfg(REG_START_ROW, 8'd31);
    add_typed(make_req(CMD_SEARCH, 0, 0, 0, 0), ST_NOPATH, 0);
    add_typed(make_req(CMD_READ, 0, 0, 0, 5), ST_NOPATH, 0);
    // oversized grid saturates, goal in the far interior corner
    add_cfg(REG_GRID_WIDTH, 8'd255);
    add_cfg(REG_GRID_HEIGHT, 8'd63);
    add_cfg(REG_START_COL, 8'd1);
    add_cfg(REG_START_ROW, 8'd1);
    add_cfg(REG_GOAL_COL, 8'd126);
    add_cfg(REG_GOAL_ROW, 8'd30);
    add_item(make_req(CMD_WRITE, 1, 1, 1, 0));  // start on a wall is allowed
    add_item(make_req(CMD_SEARCH, 0, 0, 0, 0));
    add_item(make_req(CMD_READ, 0, 0, 0, 0));
    // goal on the grid border
    add_cfg(REG_GOAL_COL, 8'd127);
    add_cfg(REG_GOAL_ROW, 8'd31);
    add_typed(make_req(CMD_SEARCH, 0, 0, 0, 0), ST_NOPATH, 0);
    // smallest grid, goal on the border
    add_cfg(REG_GRID_WIDTH, 8'd3);
    add_cfg(REG_GRID_HEIGHT, 8'd3);
    add_cfg(REG_GOAL_COL, 8'd2);
    add_cfg(REG_GOAL_ROW, 8'd2);
    add_typed(make_req(CMD_SEARCH, 0, 0, 0, 0), ST_NOPATH, 0);
    add_item(make_req(CMD_WRITE, 1, 1, 0, 0));
    run_table();

    // random phases: new grid, walls, one search, path reads, some noise
    n_rand = 0;
    phase  = 0;
    while (n_rand < 25) begin
      w = $urandom_range(3, 10);
      h = $urandom_range(3, 8);
      write_reg(REG_GRID_WIDTH, 8'(w));
      write_reg(REG_GRID_HEIGHT, 8'(h));
      write_reg(REG_START_COL, 8'($urandom_range(1, w - 2)));
      write_reg(REG_START_ROW, 8'($urandom_range(1, h - 2)));
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_GOAL_COL, 8'($urandom_range(0, 127)));
        write_reg(REG_GOAL_ROW, 8'($urandom_range(0, 31)));
      end else begin
        write_reg(REG_GOAL_COL, 8'($urandom_range(1, w - 2)));
        write_reg(REG_GOAL_ROW, 8'($urandom_range(1, h - 2)));
      end
      if (phase == 1) hold_req = 1;
      for (int k = $urandom_range(3, 12); k > 0; k--) begin
        if ($urandom_range(0, 3) == 0) begin
          col = $urandom_range(0, 127);
          row = $urandom_range(0, 31);
        end else begin
          col = $urandom_range(0, w - 1);
          row = $urandom_range(0, h - 1);
        end
        send_req(make_req(CMD_WRITE, col, row, ($urandom_range(0, 3) == 0), 0),
                 $urandom_range(0, 7), 0, '0);
        n_rand++;
      end
      send_req(make_req(CMD_SEARCH, $urandom, $urandom, 1'($urandom), $urandom),
               $urandom_range(0, 7), 0, '0);
      n_rand++;
      for (int k = $urandom_range(2, 8); k > 0; k--) begin
        if ($urandom_range(0, 4) == 0)
          wait_cyc = $urandom_range(0, 4095);
        else
          wait_cyc = $urandom_range(0, (trace_len > 0) ? trace_len : 1);
        if ($urandom_range(0, 9) == 0)
          send_req(make_req(2'd3, $urandom, $urandom, 1'($urandom), $urandom),
                   $urandom_range(0, 7), 0, '0);
        else begin
          send_req(make_req(CMD_READ, $urandom, $urandom, 1'($urandom), wait_cyc),
                   $urandom_range(0, 7), 0, '0);
          n_rand++;
        end
      end
      phase++;
    end

    @(negedge clk);
    in_valid = 0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
